@@ sv/gstss_pkg.sv @@
// Shared types, codes and constants for the gradient stop table sampler.
`default_nettype none
package gstss_pkg;

    localparam int POS_W = 19;
    localparam int COL_W = 32;
    localparam int P_W   = 28;

    localparam logic signed [POS_W-1:0] POS_MAX = 19'sd131072;
    localparam logic signed [POS_W-1:0] POS_MIN = -19'sd131072;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_INS_RD,
        ST_INS_CHK,
        ST_PINIT,
        ST_PDIV,
        ST_FIRST,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SEG,
        ST_MULA,
        ST_MULB,
        ST_CDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic cap;
        logic clr;
        logic set_full;
        logic ins_init;
        logic ins_rd;
        logic ins_shift;
        logic ins_put;
        logic mul_idx;
        logic div_init_p;
        logic div_init_c;
        logic div_step;
        logic add_p;
        logic rd_first;
        logic take_first;
        logic rd_next;
        logic adv;
        logic take_next;
        logic res_rd;
        logic res_cur;
        logic res_nxt;
        logic ch_init;
        logic mula;
        logic ch_store;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       count_zero;
        logic       count_one;
        logic       ptr_zero;
        logic       new_lt_rd;
        logic       p_lt_rd;
        logic       rd_lt_p;
        logic       lo_last;
        logic       den_le0;
        logic       div_done;
        logic       ch_last;
        logic       out_free;
    } sts_t;

    function automatic logic signed [P_W-1:0] sext_pos(input logic signed [POS_W-1:0] v);
        return P_W'(v);
    endfunction

endpackage
`default_nettype wire

@@ sv/gradient_stop_table_sampler_unit.sv @@
// Top level of the gradient stop table sampler.
`default_nettype none
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: func selects
//   insert stop, clear all stops, or sample pixel. Every beat produces exactly
//   one result beat on the output channel (out_valid / out_stall): the RGBA8
//   color for a sample, zeros otherwise, and status=1 when an insert was
//   dropped because the table holds MAX_STOPS stops already.
//   One beat is worked on at a time; in_stall is high while it is in flight.
//   Work per beat, from accept to the next accept:
//     clear / unused code / full insert: straight to the result
//     insert: one read plus one write for each stop that sorts above the
//       new one, then the new stop is written
//     sample: reciprocal multiply, then a segment search over the stops;
//       per channel: multiply, add and divider load, 8 divide steps, store.
//       Empty table, single stop or a position outside the stops end early.
//   The result sits in an output register, so a stalled receiver holds the
//   result beat steady and the next command is already accepted behind it;
//   only finishing that next command waits for the register to empty.
//   Reset empties the stop table and the output register.
module gradient_stop_table_sampler_unit #(
    parameter int MAX_STOPS = 16,
    parameter int TEXSIZE   = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic signed [18:0] position,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic [7:0]         alpha,
    input  wire logic [9:0]         pixel_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_red,
    output logic [7:0]              out_green,
    output logic [7:0]              out_blue,
    output logic [7:0]              out_alpha,
    output logic                    status
);

    gstss_pkg::cmd_t cmd;
    gstss_pkg::sts_t sts;
    logic            idle;

    // controller sequences the beat, datapath holds table and arithmetic
    gstss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    gstss_dp #(
        .MAX_STOPS (MAX_STOPS),
        .TEXSIZE   (TEXSIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .position    (position),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .pixel_index (pixel_index),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .status      (status)
    );

    // accept only when no beat is in flight
    assign in_stall = !idle;

endmodule
`default_nettype wire

@@ sv/gstss_ctrl.sv @@
// Sequencer for insert, clear and sample operations.
`default_nettype none
module gstss_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire gstss_pkg::sts_t  sts,
    output gstss_pkg::cmd_t       cmd,
    output logic                  idle
);

    gstss_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gstss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gstss_pkg::ST_IDLE:
                if (in_valid) state_next = gstss_pkg::ST_DISP;
            gstss_pkg::ST_DISP:
                unique case (sts.func)
                    gstss_pkg::FUNC_INSERT:
                        state_next = sts.full ? gstss_pkg::ST_DONE : gstss_pkg::ST_INS_RD;
                    gstss_pkg::FUNC_SAMPLE:
                        state_next = sts.count_zero ? gstss_pkg::ST_DONE : gstss_pkg::ST_PINIT;
                    default:
                        state_next = gstss_pkg::ST_DONE;
                endcase
            gstss_pkg::ST_INS_RD:
                state_next = sts.ptr_zero ? gstss_pkg::ST_DONE : gstss_pkg::ST_INS_CHK;
            gstss_pkg::ST_INS_CHK:
                state_next = sts.new_lt_rd ? gstss_pkg::ST_INS_RD : gstss_pkg::ST_DONE;
            gstss_pkg::ST_PINIT:
                state_next = gstss_pkg::ST_PDIV;
            gstss_pkg::ST_PDIV:
                if (sts.div_done) state_next = gstss_pkg::ST_FIRST;
            gstss_pkg::ST_FIRST:
                state_next = (sts.count_one || sts.p_lt_rd) ? gstss_pkg::ST_DONE
                                                            : gstss_pkg::ST_SCAN_RD;
            gstss_pkg::ST_SCAN_RD:
                state_next = sts.lo_last ? gstss_pkg::ST_DONE : gstss_pkg::ST_SCAN;
            gstss_pkg::ST_SCAN:
                state_next = sts.rd_lt_p ? gstss_pkg::ST_SCAN_RD : gstss_pkg::ST_SEG;
            gstss_pkg::ST_SEG:
                state_next = sts.den_le0 ? gstss_pkg::ST_DONE : gstss_pkg::ST_MULA;
            gstss_pkg::ST_MULA:
                state_next = gstss_pkg::ST_MULB;
            gstss_pkg::ST_MULB:
                state_next = gstss_pkg::ST_CDIV;
            gstss_pkg::ST_CDIV:
                if (sts.div_done)
                    state_next = sts.ch_last ? gstss_pkg::ST_DONE : gstss_pkg::ST_MULA;
            gstss_pkg::ST_DONE:
                if (sts.out_free) state_next = gstss_pkg::ST_IDLE;
            default:
                state_next = gstss_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        unique case (state_reg)
            gstss_pkg::ST_IDLE:
            begin
                idle    = 1'b1;
                cmd.cap = in_valid;
            end
            gstss_pkg::ST_DISP:
                unique case (sts.func)
                    gstss_pkg::FUNC_INSERT:
                    begin
                        cmd.set_full = sts.full;
                        cmd.ins_init = !sts.full;
                    end
                    gstss_pkg::FUNC_CLEAR:
                        cmd.clr = 1'b1;
                    gstss_pkg::FUNC_SAMPLE:
                        cmd.mul_idx = !sts.count_zero;
                    default:
                        cmd = '0;
                endcase
            gstss_pkg::ST_INS_RD:
            begin
                cmd.ins_put = sts.ptr_zero;
                cmd.ins_rd  = !sts.ptr_zero;
            end
            gstss_pkg::ST_INS_CHK:
            begin
                cmd.ins_shift = sts.new_lt_rd;
                cmd.ins_put   = !sts.new_lt_rd;
            end
            gstss_pkg::ST_PINIT:
                cmd.div_init_p = 1'b1;
            gstss_pkg::ST_PDIV:
            begin
                cmd.add_p    = sts.div_done;
                cmd.rd_first = sts.div_done;
                cmd.div_step = !sts.div_done;
            end
            gstss_pkg::ST_FIRST:
            begin
                cmd.res_rd     = sts.count_one || sts.p_lt_rd;
                cmd.take_first = !(sts.count_one || sts.p_lt_rd);
            end
            gstss_pkg::ST_SCAN_RD:
            begin
                cmd.res_cur = sts.lo_last;
                cmd.rd_next = !sts.lo_last;
            end
            gstss_pkg::ST_SCAN:
            begin
                cmd.adv       = sts.rd_lt_p;
                cmd.take_next = !sts.rd_lt_p;
            end
            gstss_pkg::ST_SEG:
            begin
                cmd.res_nxt = sts.den_le0;
                cmd.ch_init = !sts.den_le0;
            end
            gstss_pkg::ST_MULA:
                cmd.mula = 1'b1;
            gstss_pkg::ST_MULB:
                cmd.div_init_c = 1'b1;
            gstss_pkg::ST_CDIV:
            begin
                cmd.ch_store = sts.div_done;
                cmd.div_step = !sts.div_done;
            end
            gstss_pkg::ST_DONE:
                cmd.fin = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/gstss_dp.sv @@
// Datapath: stop memory, position math, segment search and per-channel divider.
`default_nettype none
module gstss_dp #(
    parameter int MAX_STOPS = 16,
    parameter int TEXSIZE   = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gstss_pkg::cmd_t       cmd,
    output gstss_pkg::sts_t            sts,
    input  wire logic [1:0]            func,
    input  wire logic signed [18:0]    position,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,
    input  wire logic [7:0]            alpha,
    input  wire logic [9:0]            pixel_index,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [7:0]                 out_red,
    output logic [7:0]                 out_green,
    output logic [7:0]                 out_blue,
    output logic [7:0]                 out_alpha,
    output logic                       status
);

    localparam int AW   = $clog2(MAX_STOPS);
    localparam int CW   = $clog2(MAX_STOPS + 1);
    localparam int SPAN = (TEXSIZE > 1) ? TEXSIZE - 1 : 1;
    localparam int EW   = gstss_pkg::POS_W + gstss_pkg::COL_W;
    localparam logic [16:0] Q0 = 17'(65536 / SPAN);
    localparam logic [11:0] R0 = 12'(65536 % SPAN);
    // reciprocal of the span: exact for idx*R0 < 1024*SPAN
    localparam int SB = $clog2(SPAN);
    localparam int SH = 10 + 2 * SB;
    localparam longint RMW = ((longint'(1) << SH) + longint'(SPAN) - longint'(1))
                             / longint'(SPAN);
    localparam logic [23:0] RM = 24'(RMW);

    // stop memory: {color, position}
    logic [EW-1:0] mem [MAX_STOPS];

    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    logic [CW-1:0] ptr_reg;
    logic [1:0]    func_reg;
    logic signed [18:0] new_pos_reg;
    logic [31:0]   new_col_reg;
    logic [9:0]    idx_reg;
    logic [EW-1:0] rd_reg;
    logic signed [18:0] cur_pos_reg, nxt_pos_reg;
    logic [31:0]   cur_col_reg, nxt_col_reg;
    logic signed [27:0] p_reg;
    logic [26:0]   mq_reg;
    logic [21:0]   mr_reg;
    logic [18:0]   rem_reg, dv_reg;
    logic [9:0]    lo_reg, q_reg;
    logic [3:0]    cnt_reg;
    logic [1:0]    ch_reg;
    logic [26:0]   prod_reg;
    logic [31:0]   res_reg;
    logic          stat_reg;
    logic [31:0]   ocol_reg;
    logic          ostat_reg;

    logic signed [18:0] rd_pos, sat_pos;
    logic [31:0]   rd_col;
    logic signed [19:0] den_s;
    logic signed [27:0] num_w;
    logic [18:0]   den_u, num_u;
    logic [7:0]    a_ch, b_ch;
    logic [26:0]   n_sum;
    logic [19:0]   trial;
    logic          qbit;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [CW:0]   ptr_inc;
    logic [45:0]   mr_prod;

    assign rd_pos  = rd_reg[gstss_pkg::POS_W-1:0];
    assign rd_col  = rd_reg[EW-1:gstss_pkg::POS_W];
    assign den_s   = 20'(nxt_pos_reg) - 20'(cur_pos_reg);
    assign num_w   = p_reg - gstss_pkg::sext_pos(cur_pos_reg);
    assign den_u   = den_s[18:0];
    assign num_u   = num_w[18:0];
    assign a_ch    = cur_col_reg[8*ch_reg +: 8];
    assign b_ch    = nxt_col_reg[8*ch_reg +: 8];
    assign n_sum   = prod_reg + 27'(b_ch * num_u);
    assign trial   = {rem_reg, lo_reg[9]};
    assign qbit    = (trial >= 20'(dv_reg));
    assign ptr_inc = (CW+1)'(ptr_reg) + (CW+1)'(1);
    assign mr_prod = 46'(mr_reg) * 46'(RM);

    always_comb
    begin
        if (position > gstss_pkg::POS_MAX)
            sat_pos = gstss_pkg::POS_MAX;
        else if (position < gstss_pkg::POS_MIN)
            sat_pos = gstss_pkg::POS_MIN;
        else
            sat_pos = position;
    end

    always_comb
    begin
        rd_en   = cmd.ins_rd || cmd.rd_first || cmd.rd_next;
        rd_addr = '0;
        priority if (cmd.ins_rd)
            rd_addr = AW'(ptr_reg - CW'(1));
        else if (cmd.rd_next)
            rd_addr = ptr_inc[AW-1:0];
        else
            rd_addr = '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_shift)
            mem[ptr_reg[AW-1:0]] <= rd_reg;
        else if (cmd.ins_put)
            mem[ptr_reg[AW-1:0]] <= {new_col_reg, new_pos_reg};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
            count_next = '0;
        else if (cmd.ins_put)
            count_next = count_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.fin)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            func_reg    <= func;
            new_pos_reg <= sat_pos;
            new_col_reg <= {alpha, blue, green, red};
            idx_reg     <= pixel_index;
            res_reg     <= '0;
            stat_reg    <= 1'b0;
        end
        if (cmd.set_full)
            stat_reg <= 1'b1;
        if (cmd.ins_init)
            ptr_reg <= count_reg;
        else if (cmd.ins_shift)
            ptr_reg <= ptr_reg - CW'(1);
        else if (cmd.rd_first)
            ptr_reg <= '0;
        else if (cmd.adv)
            ptr_reg <= ptr_inc[CW-1:0];
        if (cmd.mul_idx)
        begin
            mq_reg <= 27'(idx_reg * Q0);
            mr_reg <= 22'(idx_reg * R0);
        end
        // pixel position remainder: one reciprocal multiply, done at once
        if (cmd.div_init_p)
        begin
            q_reg   <= mr_prod[SH +: 10];
            cnt_reg <= 4'd0;
        end
        // channel value: restoring divider, one quotient bit per cycle
        else if (cmd.div_init_c)
        begin
            rem_reg <= n_sum[26:8];
            lo_reg  <= {n_sum[7:0], 2'b00};
            dv_reg  <= den_u;
            cnt_reg <= 4'd8;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? 19'(trial - 20'(dv_reg)) : trial[18:0];
            lo_reg  <= {lo_reg[8:0], 1'b0};
            q_reg   <= {q_reg[8:0], qbit};
            cnt_reg <= cnt_reg - 4'd1;
        end
        if (cmd.add_p)
            p_reg <= signed'(28'(mq_reg) + 28'(q_reg));
        if (cmd.take_first || cmd.adv)
        begin
            cur_pos_reg <= rd_pos;
            cur_col_reg <= rd_col;
        end
        if (cmd.take_next)
        begin
            nxt_pos_reg <= rd_pos;
            nxt_col_reg <= rd_col;
        end
        if (cmd.res_rd)
            res_reg <= rd_col;
        else if (cmd.res_cur)
            res_reg <= cur_col_reg;
        else if (cmd.res_nxt)
            res_reg <= nxt_col_reg;
        else if (cmd.ch_store)
            res_reg[8*ch_reg +: 8] <= q_reg[7:0];
        if (cmd.ch_init)
            ch_reg <= 2'd0;
        else if (cmd.ch_store)
            ch_reg <= ch_reg + 2'd1;
        if (cmd.mula)
            prod_reg <= 27'(a_ch * 19'(den_u - num_u));
        if (cmd.fin)
        begin
            ocol_reg  <= res_reg;
            ostat_reg <= stat_reg;
        end
    end

    always_comb
    begin
        sts.func       = func_reg;
        sts.full       = (count_reg == CW'(MAX_STOPS));
        sts.count_zero = (count_reg == '0);
        sts.count_one  = (count_reg == CW'(1));
        sts.ptr_zero   = (ptr_reg == '0);
        sts.new_lt_rd  = (new_pos_reg < rd_pos);
        sts.p_lt_rd    = (p_reg < gstss_pkg::sext_pos(rd_pos));
        sts.rd_lt_p    = (gstss_pkg::sext_pos(rd_pos) < p_reg);
        sts.lo_last    = (ptr_inc >= (CW+1)'(count_reg));
        sts.den_le0    = (den_s <= 20'sd0);
        sts.div_done   = (cnt_reg == 4'd0);
        sts.ch_last    = (ch_reg == 2'd3);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_red   = ocol_reg[7:0];
    assign out_green = ocol_reg[15:8];
    assign out_blue  = ocol_reg[23:16];
    assign out_alpha = ocol_reg[31:24];
    assign status    = ostat_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_STOPS))
        else $error("stop count above table size");
    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_put |-> !sts.full)
        else $error("stop written into full table");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> cnt_reg != 4'd0)
        else $error("divider stepped past its last bit");
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote an unsent beat");

endmodule
`default_nettype wire

@@ tb/tb_gradient_stop_table_sampler_unit.sv @@
// Testbench for the gradient stop table sampler: directed table plus random beats.
`timescale 1ns / 1ps
`default_nettype none
module tb_gradient_stop_table_sampler_unit;

    localparam int NSTOPS   = 16;
    localparam int TEX      = 1024;
    localparam int N_RANDOM = 1400;
    localparam int LIMIT    = 2000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic signed [18:0] position;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [9:0]         pixel_index;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic               status;

    // One command beat and one result beat.
    typedef struct {
        logic [1:0]         f;
        logic signed [18:0] pos;
        logic [7:0]         r, g, b, a;
        logic [9:0]         pix;
    } cmd_beat_t;

    typedef struct {
        logic [7:0] r, g, b, a;
        logic       st;
    } color_beat_t;

    // Directed row: command plus an optional hand-typed result.
    typedef struct {
        cmd_beat_t   c;
        logic        typed;
        color_beat_t res;
    } ramp_row_t;

    gradient_stop_table_sampler_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .position(position),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .pixel_index(pixel_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha), .status(status)
    );

    // Predictor copy of the stop table.
    int          stop_pos [NSTOPS];
    logic [31:0] stop_col [NSTOPS];
    int          stop_cnt;

    color_beat_t expected_colors[$];
    int          err_count;
    int          cycle_count;
    bit          hold_long;
    bit          stim_done;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    // Color of the ramp at fixed-point position p.
    function automatic logic [31:0] ramp_color(input longint p);
        int          lo;
        longint      p0, p1, den, num, ca, cb, v;
        logic [31:0] c0, c1, res;
        if (stop_cnt == 0)
            return 32'd0;
        if (stop_cnt == 1 || p < stop_pos[0])
            return stop_col[0];
        lo = 0;
        while (lo + 1 < stop_cnt && stop_pos[lo + 1] < p)
            lo++;
        if (lo + 1 >= stop_cnt)
            return stop_col[stop_cnt - 1];
        p0 = stop_pos[lo];
        p1 = stop_pos[lo + 1];
        c0 = stop_col[lo];
        c1 = stop_col[lo + 1];
        den = p1 - p0;
        if (den <= 0)
            return c1;
        num = p - p0;
        res = '0;
        for (int k = 0; k < 4; k++)
        begin
            ca = c0[8*k +: 8];
            cb = c1[8*k +: 8];
            v = (ca * den + (cb - ca) * num) / den;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res[8*k +: 8] = v[7:0];
        end
        return res;
    endfunction

    // Applies one command to the table copy and gives its result.
    function automatic color_beat_t ramp_apply(input cmd_beat_t c);
        color_beat_t o;
        int          p, at;
        logic [31:0] col;
        o = '{default: '0};
        col = '0;
        if (c.f == gstss_pkg::FUNC_INSERT)
        begin
            if (stop_cnt >= NSTOPS)
            begin
                o.st = 1'b1;
            end
            else
            begin
                p = int'(c.pos);
                if (p > 131072) p = 131072;
                if (p < -131072) p = -131072;
                at = 0;
                while (at < stop_cnt && !(p < stop_pos[at]))
                    at++;
                for (int i = stop_cnt; i > at; i--)
                begin
                    stop_pos[i] = stop_pos[i - 1];
                    stop_col[i] = stop_col[i - 1];
                end
                stop_pos[at] = p;
                stop_col[at] = {c.a, c.b, c.g, c.r};
                stop_cnt++;
            end
        end
        else if (c.f == gstss_pkg::FUNC_CLEAR)
        begin
            stop_cnt = 0;
        end
        else if (c.f == gstss_pkg::FUNC_SAMPLE)
        begin
            col = ramp_color((longint'(c.pix) * 65536) / (TEX - 1));
        end
        o.r = col[7:0];
        o.g = col[15:8];
        o.b = col[23:16];
        o.a = col[31:24];
        return o;
    endfunction

    function automatic cmd_beat_t mk(input logic [1:0] f, input int pos,
                                     input logic [31:0] rgba, input int pix);
        cmd_beat_t c;
        c.f = f;
        c.pos = 19'(pos);
        {c.a, c.b, c.g, c.r} = rgba;
        c.pix = 10'(pix);
        return c;
    endfunction

    function automatic cmd_beat_t rand_cmd();
        cmd_beat_t c;
        int        sel;
        sel = $urandom_range(0, 99);
        c = mk(gstss_pkg::FUNC_SAMPLE, 0, $urandom, $urandom_range(0, 1023));
        if (sel < 40)
            c.f = gstss_pkg::FUNC_INSERT;
        else if (sel < 44)
            c.f = gstss_pkg::FUNC_CLEAR;
        else if (sel < 46)
            c.f = gstss_pkg::FUNC_NONE;
        // Mostly positions within the ramp, some across the whole field.
        if ($urandom_range(0, 3) == 0)
            c.pos = 19'($urandom);
        else if ($urandom_range(0, 5) == 0)
            c.pos = 19'(65536 * $urandom_range(0, 1));
        else
            c.pos = 19'($urandom_range(0, 65536));
        return c;
    endfunction

    // Sender: offers a beat and holds it until accepted. Valid stays high
    // into the next beat when no gap follows.
    task automatic send_beat(input cmd_beat_t c, input logic typed, input color_beat_t r);
        int          gap;
        color_beat_t pred;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= c.f;
        position    <= c.pos;
        red         <= c.r;
        green       <= c.g;
        blue        <= c.b;
        alpha       <= c.a;
        pixel_index <= c.pix;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred = ramp_apply(c);
        expected_colors.push_back(typed ? r : pred);
    endtask

    ramp_row_t rows[$];

    task automatic add_row(input cmd_beat_t c, input logic typed, input color_beat_t r);
        ramp_row_t row;
        row.c = c;
        row.typed = typed;
        row.res = r;
        rows.push_back(row);
    endtask

    color_beat_t zero_res, full_res;

    // Stimulus.
    initial
    begin
        in_valid = 1'b0;
        func = '0; position = '0; red = '0; green = '0; blue = '0; alpha = '0;
        pixel_index = '0;
        rst_n = 1'b0;
        stop_cnt = 0;
        err_count = 0;
        stim_done = 1'b0;
        zero_res = '{default: '0};
        full_res = '{default: '0};
        full_res.st = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then single stop, ends, zero-width segment, saturation, full table.
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 0), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 1023), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_NONE, -1, 32'hffffffff, 1023), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_INSERT, 32768, 32'h80402010, 0), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 0), 1'b1,
                '{8'h10, 8'h20, 8'h40, 8'h80, 1'b0});
        add_row(mk(gstss_pkg::FUNC_INSERT, -262144, 32'h00000000, 0), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_INSERT, 262143, 32'hffffffff, 0), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 511), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 1023), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_INSERT, 32768, 32'h00ff00ff, 0), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 512), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 500), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_CLEAR, 0, 0, 0), 1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 700), 1'b1, zero_res);
        for (int i = 0; i < 16; i++)
            add_row(mk(gstss_pkg::FUNC_INSERT, 4096 * i, 32'h01010101 * i * 16, 0),
                    1'b1, zero_res);
        add_row(mk(gstss_pkg::FUNC_INSERT, 100, 32'h12345678, 0), 1'b1, full_res);
        add_row(mk(gstss_pkg::FUNC_SAMPLE, 0, 0, 300), 1'b0, zero_res);
        add_row(mk(gstss_pkg::FUNC_CLEAR, 0, 0, 0), 1'b1, zero_res);

        foreach (rows[i])
            send_beat(rows[i].c, rows[i].typed, rows[i].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Long receiver hold-off partway through.
            if (n == 300) hold_long = 1'b1;
            send_beat(rand_cmd(), 1'b0, zero_res);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall: random gaps, plus one long hold while the sender runs on.
    initial
    begin
        out_stall = 1'b0;
        hold_long = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3))
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        color_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_colors.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 0);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (out_red   !== want.r) report_mismatch("out_red", out_red, want.r);
                if (out_green !== want.g) report_mismatch("out_green", out_green, want.g);
                if (out_blue  !== want.b) report_mismatch("out_blue", out_blue, want.b);
                if (out_alpha !== want.a) report_mismatch("out_alpha", out_alpha, want.a);
                if (status    !== want.st) report_mismatch("status", status, want.st);
            end
        end
    end

    // Drain, then verdict; cycle limit as a watchdog.
    initial
    begin
        cycle_count = 0;
        while (!(stim_done && expected_colors.size() == 0) && cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= LIMIT)
        begin
            $display("tb_gradient_stop_table_sampler_unit: errors");
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (err_count == 0 && expected_colors.size() == 0)
                $display("tb_gradient_stop_table_sampler_unit: clean");
            else
                $display("tb_gradient_stop_table_sampler_unit: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
